FILE: src/bope_pkg.sv
// Shared types, constants and byte/digit helper functions for the
// byte-offset pair digit encoder. No dependencies.
package bope_pkg;

  localparam int QUEUE_DEPTH = 4;

  // Control-character remaps before the offset is applied.
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_BELL      = 8'd7;
  localparam logic [7:0] MAP_NEWLINE    = 8'd127;
  localparam logic [7:0] MAP_TAB        = 8'd128;
  localparam logic [7:0] MAP_BACKSPACE  = 8'd129;
  localparam logic [7:0] MAP_BELL       = 8'd130;
  localparam logic [7:0] BYTE_OFFSET    = 8'd68;

  // Lead code for a pair of repdigit (multiple of 11 mod 100) bytes.
  localparam logic [7:0] REPDIGIT_CODE  = 8'd25;

  // Reciprocal of 10: (v * 205) >> 11 is exact for v < 1029.
  localparam logic [7:0] RECIP10        = 8'd205;
  localparam int         RECIP10_SHIFT  = 11;

  // One queue entry: one or two codes, last flag applies to the final code.
  typedef struct packed {
    logic [7:0] code0;
    logic [7:0] code1;
    logic       two;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic [4:0] tens_full;  // v / 10
    logic [3:0] tens;       // (v mod 100) / 10
    logic [3:0] units;      // v mod 10
    logic       rep11;      // (v mod 100) is a multiple of 11
  } digits_t;

  function automatic logic [7:0] map_byte(input logic [7:0] c);
    logic [7:0] v;
    priority if (c == CHAR_NEWLINE)   v = MAP_NEWLINE;
    else if (c == CHAR_TAB)           v = MAP_TAB;
    else if (c == CHAR_BACKSPACE)     v = MAP_BACKSPACE;
    else if (c == CHAR_BELL)          v = MAP_BELL;
    else                              v = c;
    return v + BYTE_OFFSET;
  endfunction

  function automatic digits_t split(input logic [7:0] v);
    digits_t    d;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  q8;
    logic [7:0]  u8;
    logic [4:0]  t;
    prod = {8'd0, v} * {8'd0, RECIP10};
    q    = prod[RECIP10_SHIFT +: 5];
    q8   = {3'd0, q};
    u8   = v - ((q8 << 3) + (q8 << 1));
    priority if (q >= 5'd20) t = q - 5'd20;
    else if (q >= 5'd10)     t = q - 5'd10;
    else                     t = q;
    d.tens_full = q;
    d.tens      = t[3:0];
    d.units     = u8[3:0];
    d.rep11     = (t[3:0] == u8[3:0]);
    return d;
  endfunction

  // hi*10 + lo for two decimal digits
  function automatic logic [7:0] join_digits(input logic [3:0] hi, input logic [3:0] lo);
    logic [7:0] h;
    h = {4'd0, hi};
    return (h << 3) + (h << 1) + {4'd0, lo};
  endfunction

endpackage

FILE: src/bope_if.sv
// Valid/ready channel interfaces for input characters and output codes.
// No dependencies.
interface bope_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_in;

  modport source (output valid, output char_in, output last_in, input ready);
  modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

interface bope_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_out;
  logic       last_out;

  modport source (output valid, output code_out, output last_out, input ready);
  modport sink   (input valid, input code_out, input last_out, output ready);
endinterface

FILE: src/bope_front.sv
// Front end: maps each character, holds the pending byte, classifies the
// pairing and pushes at most one queue entry per character. Depends on bope_pkg, bope_if.
module bope_front (
  input  logic            clk,
  input  logic            rst,
  bope_char_if.sink       char_chan,
  input  logic            q_full,
  output logic            push,
  output bope_pkg::entry_t push_entry
);
  import bope_pkg::*;

  logic [7:0] pending_code;
  logic       pending_valid;

  logic [7:0] n_code;
  digits_t    dn;
  digits_t    dp;
  logic       accept;
  logic       paired;
  logic [7:0] pc0;
  logic [7:0] pc1;

  assign char_chan.ready = !q_full;
  assign accept          = char_chan.valid && !q_full;

  assign n_code = map_byte(char_chan.char_in);
  assign dn     = split(n_code);
  assign dp     = split(pending_code);

  always_comb begin
    paired = 1'b1;
    pc0    = 8'd0;
    pc1    = join_digits(dp.units, dn.units);
    priority if (pending_code == n_code) begin
      pc0 = {4'd0, dp.tens} + 8'd1;
      pc1 = {4'd0, dp.units} + 8'd1;
    end else if (dp.tens_full == dn.tens_full) begin
      pc0 = {3'd0, dp.tens_full} + 8'd1;
    end else if (dp.rep11 && dn.rep11) begin
      pc0 = REPDIGIT_CODE;
    end else begin
      paired = 1'b0;
    end
  end

  always_comb begin
    push_entry = '0;
    push       = 1'b0;
    if (pending_valid && paired) begin
      push_entry.code0 = pc0;
      push_entry.code1 = pc1;
      push_entry.two   = 1'b1;
      push_entry.last  = char_chan.last_in;
      push             = accept;
    end else if (pending_valid) begin
      // pending byte goes out alone; flush the new one too on last
      push_entry.code0 = pending_code;
      push_entry.code1 = n_code;
      push_entry.two   = char_chan.last_in;
      push_entry.last  = char_chan.last_in;
      push             = accept;
    end else begin
      push_entry.code0 = n_code;
      push_entry.code1 = n_code;
      push_entry.two   = 1'b0;
      push_entry.last  = 1'b1;
      push             = accept && char_chan.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_code  <= '0;
    end else if (accept) begin
      if ((pending_valid && paired) || char_chan.last_in) begin
        pending_valid <= 1'b0;
        pending_code  <= '0;
      end else begin
        pending_valid <= 1'b1;
        pending_code  <= n_code;
      end
    end
  end

endmodule

FILE: src/bope_queue.sv
// Small FIFO of encoder entries between front and back ends.
// Depends on bope_pkg.
module bope_queue #(
  parameter int Depth = bope_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bope_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output bope_pkg::entry_t head
);
  import bope_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == FullCnt);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/bope_back.sv
// Back end: serializes each queue entry into one or two output code beats.
// Depends on bope_pkg, bope_if.
module bope_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  bope_pkg::entry_t head,
  output logic             pop,
  bope_code_if.source      code_chan
);
  import bope_pkg::*;

  logic second;   // emitting the second code of a two-code entry
  logic fire;

  assign code_chan.valid    = !empty;
  assign code_chan.code_out = second ? head.code1 : head.code0;
  assign code_chan.last_out = head.last && (second || !head.two);

  assign fire = code_chan.valid && code_chan.ready;
  assign pop  = fire && (second || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (fire) begin
      second <= head.two && !second;
    end
  end

endmodule

FILE: src/byte_offset_pair_digit_encoder.sv
// Byte-offset pair digit encoder, top level.
// Depends on bope_pkg, bope_if, bope_front, bope_queue, bope_back.
// Input takes one character per cycle while the queue is not full; an entry
//   is written to the queue when the character that completes it is taken,
//   then drains as one or two beats through the back end's single code port.
// Reset (rst, synchronous): clears pending byte, queue pointers and back-end
//   phase; input ready rises in the first cycle after reset.
module byte_offset_pair_digit_encoder #(
  parameter int QueueDepth = bope_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  bope_char_if.sink   char_chan,
  bope_code_if.source code_chan
);
  import bope_pkg::*;

  // front -> queue
  logic   push;
  entry_t push_entry;
  // queue status and head
  logic   q_full;
  logic   q_empty;
  entry_t head;
  // back -> queue
  logic   pop;

  // Front: map, hold pending byte, decide pair / single / flush.
  bope_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_chan  (char_chan),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue decouples input acceptance from output stalls.
  bope_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  // Back: one code beat per cycle while the consumer takes them.
  bope_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .code_chan (code_chan)
  );

endmodule

FILE: src/bope_checker.sv
// Port-level checks for the encoder top level, attached by bind.
// Depends on the top level's port names only.
module bope_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_code,
  input logic       out_last
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_last))
    else $error("output beat changed while stalled");

  // nothing to emit right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a last character always produces at least one code
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("no output after last character");

  // input only backs up when codes are waiting
  a_full_has_data: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no output pending");

endmodule

bind byte_offset_pair_digit_encoder bope_checker u_bope_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (char_chan.valid),
  .in_ready  (char_chan.ready),
  .in_last   (char_chan.last_in),
  .out_valid (code_chan.valid),
  .out_ready (code_chan.ready),
  .out_code  (code_chan.code_out),
  .out_last  (code_chan.last_out)
);

FILE: tb/byte_offset_pair_digit_encoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for byte_offset_pair_digit_encoder.
// Needs bope_pkg, bope_if and the encoder RTL; drives both channels itself.
module byte_offset_pair_digit_encoder_test;

  // Control characters that are remapped before the offset.
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_BELL      = 8'd7;
  localparam logic [7:0] ALT_NEWLINE   = 8'd127;
  localparam logic [7:0] ALT_TAB       = 8'd128;
  localparam logic [7:0] ALT_BACKSPACE = 8'd129;
  localparam logic [7:0] ALT_BELL      = 8'd130;
  localparam logic [7:0] CHAR_OFFSET   = 8'd68;
  // Lead code of a pair of repdigit values.
  localparam logic [7:0] REPDIGIT_LEAD = 8'd25;

  localparam int DIR_ROWS    = 25;
  localparam int RAND_ITEMS  = 1700;
  localparam int QUIET_ITEMS = 250;     // tail of the run without idling
  localparam int HOLD_CYCLES = 200;     // long output hold-off
  localparam int DRAIN       = 20;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_beat_t;

  // One directed beat; known rows carry their expected codes inline.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       known;
    logic [1:0] cnt;
    logic [7:0] c0;
    logic       l0;
    logic [7:0] c1;
    logic       l1;
  } char_row_t;

  logic clk;
  logic rst;

  bope_char_if char_chan ();
  bope_code_if code_chan ();

  byte_offset_pair_digit_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .char_chan (char_chan),
    .code_chan (code_chan)
  );

  char_row_t  directed_rows [DIR_ROWS];
  code_beat_t awaited_codes [$];

  // Predictor state: the byte waiting for a partner.
  logic [7:0] held_byte;
  logic       held_valid;

  int mismatches;
  int chars_taken;

  // Handshake between stimulus, receiver and sender idling.
  bit hold_req;
  bit hold_active;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Control remap, then the fixed offset, wrapping at 8 bits.
  function automatic logic [7:0] offset_char(input logic [7:0] raw);
    logic [7:0] v;
    case (raw)
      CH_NEWLINE:   v = ALT_NEWLINE;
      CH_TAB:       v = ALT_TAB;
      CH_BACKSPACE: v = ALT_BACKSPACE;
      CH_BELL:      v = ALT_BELL;
      default:      v = raw;
    endcase
    return v + CHAR_OFFSET;
  endfunction

  // Greedy pairing of the held byte with the new one. Returns 0..2 codes
  // and advances the held-byte state.
  function automatic void encode_char(input logic [7:0] raw, input logic fin,
                                      output int count, output code_beat_t beat_a,
                                      output code_beat_t beat_b);
    int         m;
    int         p;
    bit         paired;
    logic [7:0] lead;
    logic [7:0] tail;
    m      = offset_char(raw);
    p      = held_byte;
    count  = 0;
    paired = 1'b0;
    beat_a = '0;
    beat_b = '0;
    lead   = '0;
    tail   = '0;
    if (held_valid) begin
      paired = 1'b1;
      if (p == m) begin
        lead = 8'((p % 100) / 10 + 1);
        tail = 8'(p % 10 + 1);
      end else if (p / 10 == m / 10) begin
        // same tens over the full value, hundreds included
        lead = 8'(p / 10 + 1);
        tail = 8'((p % 10) * 10 + m % 10);
      end else if ((p % 100) % 11 == 0 && (m % 100) % 11 == 0) begin
        lead = REPDIGIT_LEAD;
        tail = 8'((p % 10) * 10 + m % 10);
      end else begin
        paired = 1'b0;
      end
      if (paired) begin
        beat_a     = '{lead, 1'b0};
        beat_b     = '{tail, fin};
        count      = 2;
        held_valid = 1'b0;
        held_byte  = '0;
      end else begin
        // no partner: the held byte leaves alone
        beat_a = '{held_byte, 1'b0};
        count  = 1;
      end
    end
    if (!paired) begin
      if (fin) begin
        if (count == 0) beat_a = '{8'(m), 1'b1};
        else beat_b = '{8'(m), 1'b1};
        count      = count + 1;
        held_valid = 1'b0;
        held_byte  = '0;
      end else begin
        held_byte  = 8'(m);
        held_valid = 1'b1;
      end
    end
  endfunction

  // Watches both channels at each edge: accepted characters feed the
  // predictor first, then an accepted code is checked against the oldest
  // awaited one. One process, so same-edge ordering cannot matter.
  always @(posedge clk) begin
    int         n;
    code_beat_t beat_a;
    code_beat_t beat_b;
    code_beat_t want;
    if (rst) begin
      held_byte   = '0;
      held_valid  = 1'b0;
      chars_taken <= 0;
    end else begin
      if (char_chan.valid && char_chan.ready) begin
        encode_char(char_chan.char_in, char_chan.last_in, n, beat_a, beat_b);
        if (chars_taken < DIR_ROWS && directed_rows[chars_taken].known) begin
          n      = directed_rows[chars_taken].cnt;
          beat_a = '{directed_rows[chars_taken].c0, directed_rows[chars_taken].l0};
          beat_b = '{directed_rows[chars_taken].c1, directed_rows[chars_taken].l1};
        end
        if (n > 0) awaited_codes.push_back(beat_a);
        if (n > 1) awaited_codes.push_back(beat_b);
        chars_taken <= chars_taken + 1;
      end
      if (code_chan.valid && code_chan.ready) begin
        if (awaited_codes.size() == 0) begin
          $display("%0t: unexpected code beat %0d last %0b, none awaited",
                   $time, code_chan.code_out, code_chan.last_out);
          mismatches++;
        end else begin
          want = awaited_codes.pop_front();
          if (code_chan.code_out !== want.code) begin
            $display("%0t: code_out expected %0d, actual %0d",
                     $time, want.code, code_chan.code_out);
            mismatches++;
          end
          if (code_chan.last_out !== want.last) begin
            $display("%0t: last_out expected %0b, actual %0b",
                     $time, want.last, code_chan.last_out);
            mismatches++;
          end
        end
      end
    end
  end

  // Output side: random stall bursts with a changing rate, one long
  // hold-off on request, and no stalls once the run goes quiet.
  initial begin
    int odds;
    int cycle;
    odds  = 0;
    cycle = 0;
    code_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       odds = 0;
          1:       odds = 12;
          default: odds = 3;
        endcase
      end
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        code_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        code_chan.ready <= 1'b1;
      end else if (!quiet && odds != 0 && $urandom_range(1, odds) == 1) begin
        code_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        code_chan.ready <= 1'b1;
      end else begin
        code_chan.ready <= 1'b1;
      end
    end
  end

  // Run limit, well above the slowest legal run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  int tx_odds;

  // Presents one character beat and returns at the edge that takes it,
  // then maybe idles the input for a burst. Valid stays up otherwise.
  task automatic offer_char(input logic [7:0] ch, input logic fin);
    char_chan.valid   <= 1'b1;
    char_chan.char_in <= ch;
    char_chan.last_in <= fin;
    @(posedge clk);
    while (!char_chan.ready) @(posedge clk);
    if (!quiet && !hold_active && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      char_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  initial begin
    int         i;
    int         str_left;
    int         m;
    logic [7:0] ch;
    logic [7:0] prev;
    logic       fin;

    mismatches  = 0;
    hold_req    = 1'b0;
    hold_active = 1'b0;
    quiet       = 1'b0;
    tx_odds     = 4;
    rst               <= 1'b1;
    char_chan.valid   <= 1'b0;
    char_chan.char_in <= '0;
    char_chan.last_in <= 1'b0;

    // Directed beats: control remaps and wraparound, each pairing rule,
    // flush at last with and without a held byte, string boundaries.
    //                  char           last  known cnt  code0  l0    code1  l1
    directed_rows[0]  = '{8'd0,         1'b1, 1'b1, 2'd1, 8'd68,  1'b1, 8'd0,  1'b0};
    directed_rows[1]  = '{8'd255,       1'b1, 1'b1, 2'd1, 8'd67,  1'b1, 8'd0,  1'b0};
    directed_rows[2]  = '{CH_NEWLINE,   1'b1, 1'b1, 2'd1, 8'd195, 1'b1, 8'd0,  1'b0};
    directed_rows[3]  = '{CH_TAB,       1'b1, 1'b1, 2'd1, 8'd196, 1'b1, 8'd0,  1'b0};
    directed_rows[4]  = '{CH_BACKSPACE, 1'b1, 1'b1, 2'd1, 8'd197, 1'b1, 8'd0,  1'b0};
    directed_rows[5]  = '{CH_BELL,      1'b1, 1'b1, 2'd1, 8'd198, 1'b1, 8'd0,  1'b0};
    // zero byte is plain data; equal pair 68,68
    directed_rows[6]  = '{8'd0,         1'b0, 1'b1, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};
    directed_rows[7]  = '{8'd0,         1'b1, 1'b1, 2'd2, 8'd7,   1'b0, 8'd9,  1'b1};
    // same tens 69,68
    directed_rows[8]  = '{8'd1,         1'b0, 1'b1, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};
    directed_rows[9]  = '{8'd0,         1'b1, 1'b1, 2'd2, 8'd7,   1'b0, 8'd98, 1'b1};
    // repdigits 88,99
    directed_rows[10] = '{8'd20,        1'b0, 1'b1, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};
    directed_rows[11] = '{8'd31,        1'b1, 1'b1, 2'd2, 8'd25,  1'b0, 8'd89, 1'b1};
    // unpaired mid-string, then the new byte pairs with the next one
    directed_rows[12] = '{8'd20,        1'b0, 1'b1, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};
    directed_rows[13] = '{8'd0,         1'b0, 1'b1, 2'd1, 8'd88,  1'b0, 8'd0,  1'b0};
    directed_rows[14] = '{8'd0,         1'b1, 1'b1, 2'd2, 8'd7,   1'b0, 8'd9,  1'b1};
    // top tens 255,250
    directed_rows[15] = '{8'd187,       1'b0, 1'b1, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};
    directed_rows[16] = '{8'd182,       1'b1, 1'b1, 2'd2, 8'd26,  1'b0, 8'd50, 1'b1};
    // repdigits across hundreds 111,11
    directed_rows[17] = '{8'd43,        1'b0, 1'b1, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};
    directed_rows[18] = '{8'd199,       1'b1, 1'b1, 2'd2, 8'd25,  1'b0, 8'd11, 1'b1};
    // 0 and 100 pair as repdigits, not at the end of the string
    directed_rows[19] = '{8'd188,       1'b0, 1'b1, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};
    directed_rows[20] = '{8'd32,        1'b0, 1'b1, 2'd2, 8'd25,  1'b0, 8'd0,  1'b0};
    // unpaired at last: held byte, then the new one carries last
    directed_rows[21] = '{8'd20,        1'b0, 1'b1, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};
    directed_rows[22] = '{8'd0,         1'b1, 1'b1, 2'd2, 8'd88,  1'b0, 8'd68, 1'b1};
    // equal pair at 255, left to the predictor
    directed_rows[23] = '{8'd187,       1'b0, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};
    directed_rows[24] = '{8'd187,       1'b1, 1'b0, 2'd0, 8'd0,   1'b0, 8'd0,  1'b0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      offer_char(directed_rows[i].ch, directed_rows[i].fin);
    end

    // Long output hold-off while characters keep coming.
    hold_req = 1'b1;

    // Random strings. Most beats are picked to hit a pairing rule against
    // the previous byte; the rest are control bytes and plain noise, and a
    // few strings end early.
    str_left = 0;
    prev     = '0;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_odds = 0;
          1:       tx_odds = 12;
          default: tx_odds = 3;
        endcase
      end
      if (str_left == 0) begin
        str_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40)
                                               : $urandom_range(1, 12);
      end
      case ($urandom_range(0, 9))
        0, 1: ch = prev;
        2, 3: begin
          m = (offset_char(prev) / 10) * 10 + $urandom_range(0, 9);
          if (m > 255) m = 255;
          ch = 8'(m) - CHAR_OFFSET;
        end
        4, 5: begin
          m = $urandom_range(0, 2) * 100 + $urandom_range(0, 9) * 11;
          if (m > 255) m = m - 100;
          ch = 8'(m) - CHAR_OFFSET;
        end
        6:       ch = 8'($urandom_range(CH_BELL, CH_NEWLINE));
        default: ch = 8'($urandom_range(0, 255));
      endcase
      fin = (str_left == 1) || ($urandom_range(0, 19) == 0);
      str_left = fin ? 0 : str_left - 1;
      prev = ch;
      offer_char(ch, fin);
    end
    char_chan.valid <= 1'b0;

    while (awaited_codes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0 && awaited_codes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
